// File: hw/rtl/ihpq_pkg.sv
package ihpq_pkg;

	localparam int MaxElements = 64;
	localparam int IdW = 7;
	localparam int SlotW = 7;
	localparam int AddrW = 6;
	localparam int PriW = 32;

	typedef logic [IdW-1:0] id_t;
	typedef logic [SlotW-1:0] slot_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic signed [PriW-1:0] pri_t;

	typedef struct packed {
		id_t id;
		pri_t pri;
	} entry_t;

	localparam logic [1:0] ACT_PUT = 2'd0;
	localparam logic [1:0] ACT_POP = 2'd1;
	localparam logic [1:0] ACT_INV = 2'd2;
	localparam logic [1:0] ACT_QRY = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INS,
		OP_CHG_RD,
		OP_CHG,
		OP_REM,
		OP_INV,
		OP_UP_RD,
		OP_UP_MOVE,
		OP_DN_RD,
		OP_DN_MOVE,
		OP_FIN,
		OP_INV_RD,
		OP_INV_LD,
		OP_RPT_RD,
		OP_RPT_PRI,
		OP_RPT_OUT
	} op_t;

	typedef struct packed {
		logic [1:0] act;
		logic id_ok;
		logic pos_hit;
		logic heap_empty;
		logic heap_one;
		logic heap_full;
		logic chg_up;
		logic chg_dn;
		logic has_parent;
		logic up_go;
		logic has_child;
		logic dn_go;
		logic inv_more;
	} stat_t;

	function automatic logic ranks_before(input logic min_first, input pri_t a, input pri_t b);
		ranks_before = min_first ? (a < b) : (a > b);
	endfunction

	function automatic addr_t slot_addr(input slot_t s);
		slot_addr = AddrW'(s - SlotW'(1));
	endfunction

endpackage

// File: hw/rtl/ihpq_in_if.sv
interface ihpq_in_if;
	import ihpq_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] action;
	id_t element_id;
	pri_t priority_value;

	modport source (output valid, output action, output element_id, output priority_value,
		input ready);
	modport sink (input valid, input action, input element_id, input priority_value,
		output ready);
endinterface

// File: hw/rtl/ihpq_out_if.sv
interface ihpq_out_if;
	import ihpq_pkg::*;

	logic valid;
	logic ready;
	logic is_empty;
	id_t held_count;
	id_t top_element;
	pri_t top_priority;
	logic element_present;
	pri_t element_priority;

	modport source (output valid, output is_empty, output held_count, output top_element,
		output top_priority, output element_present, output element_priority, input ready);
	modport sink (input valid, input is_empty, input held_count, input top_element,
		input top_priority, input element_present, input element_priority, output ready);
endinterface

// File: hw/rtl/ihpq_dpath.sv
module ihpq_dpath (
	input logic clk,
	input logic arst_n,
	input ihpq_pkg::op_t op,
	input logic [1:0] in_action,
	input ihpq_pkg::id_t in_id,
	input ihpq_pkg::pri_t in_pri,
	output ihpq_pkg::stat_t stat,
	output logic is_empty,
	output ihpq_pkg::id_t held_count,
	output ihpq_pkg::id_t top_element,
	output ihpq_pkg::pri_t top_priority,
	output logic element_present,
	output ihpq_pkg::pri_t element_priority
);
	import ihpq_pkg::*;

	entry_t heap_mem [MaxElements];
	slot_t pos_mem [MaxElements];
	logic [MaxElements-1:0] map_vld_q;

	slot_t fill_q;
	logic min_first_q;

	logic [1:0] act_q;
	id_t id_q;
	pri_t val_q;
	entry_t cur_q;
	slot_t p_q;
	slot_t i_q;
	entry_t ra_q;
	entry_t rb_q;
	slot_t pd_q;
	logic pv_q;

	logic is_empty_q;
	id_t held_count_q;
	id_t top_element_q;
	pri_t top_priority_q;
	logic element_present_q;
	pri_t element_priority_q;

	logic re_a, re_b, re_p, we_h, we_p;
	addr_t addr_a, addr_b, addr_p, wa_h, wa_p;
	entry_t wd_h;
	slot_t wd_p;

	logic [SlotW:0] two_p, two_p1, fill_w;
	logic has_right, pick_r, id_ok, present;
	entry_t child;
	slot_t cidx;

	assign two_p = {p_q, 1'b0};
	assign two_p1 = two_p + (SlotW+1)'(1);
	assign fill_w = {1'b0, fill_q};
	assign has_right = two_p1 <= fill_w;
	assign pick_r = has_right && ranks_before(min_first_q, rb_q.pri, ra_q.pri);
	assign child = pick_r ? rb_q : ra_q;
	assign cidx = pick_r ? two_p1[SlotW-1:0] : two_p[SlotW-1:0];
	assign id_ok = (id_q != '0) && (id_q <= IdW'(MaxElements));
	assign present = id_ok && pv_q;

	always_comb begin
		stat.act = act_q;
		stat.id_ok = id_ok;
		stat.pos_hit = pv_q;
		stat.heap_empty = fill_q == '0;
		stat.heap_one = fill_q == SlotW'(1);
		stat.heap_full = fill_q == SlotW'(MaxElements);
		stat.chg_up = ranks_before(min_first_q, val_q, ra_q.pri);
		stat.chg_dn = ranks_before(min_first_q, ra_q.pri, val_q);
		stat.has_parent = p_q > SlotW'(1);
		stat.up_go = ranks_before(min_first_q, cur_q.pri, ra_q.pri);
		stat.has_child = two_p <= fill_w;
		stat.dn_go = ranks_before(min_first_q, child.pri, cur_q.pri);
		stat.inv_more = i_q <= fill_q;
	end

	always_comb begin
		re_a = 1'b0;
		re_b = 1'b0;
		re_p = 1'b0;
		we_h = 1'b0;
		we_p = 1'b0;
		addr_a = '0;
		addr_b = '0;
		addr_p = '0;
		wa_h = '0;
		wa_p = '0;
		wd_h = cur_q;
		wd_p = p_q;
		case (op)
			OP_LOAD: begin
				re_a = 1'b1;
				addr_a = slot_addr(SlotW'(1));
				re_b = 1'b1;
				addr_b = slot_addr(fill_q);
				re_p = 1'b1;
				addr_p = AddrW'(in_id - IdW'(1));
			end
			OP_CHG_RD: begin
				re_a = 1'b1;
				addr_a = slot_addr(pd_q);
			end
			OP_UP_RD: begin
				re_a = 1'b1;
				addr_a = slot_addr({1'b0, p_q[SlotW-1:1]});
			end
			OP_UP_MOVE: begin
				we_h = 1'b1;
				wa_h = slot_addr(p_q);
				wd_h = ra_q;
				we_p = 1'b1;
				wa_p = AddrW'(ra_q.id - IdW'(1));
			end
			OP_DN_RD: begin
				re_a = 1'b1;
				addr_a = slot_addr(two_p[SlotW-1:0]);
				re_b = 1'b1;
				addr_b = slot_addr(two_p1[SlotW-1:0]);
			end
			OP_DN_MOVE: begin
				we_h = 1'b1;
				wa_h = slot_addr(p_q);
				wd_h = child;
				we_p = 1'b1;
				wa_p = AddrW'(child.id - IdW'(1));
			end
			OP_FIN: begin
				we_h = 1'b1;
				wa_h = slot_addr(p_q);
				we_p = 1'b1;
				wa_p = AddrW'(cur_q.id - IdW'(1));
			end
			OP_INV_RD: begin
				re_a = 1'b1;
				addr_a = slot_addr(i_q);
			end
			OP_RPT_RD: begin
				re_a = 1'b1;
				addr_a = slot_addr(SlotW'(1));
				re_p = 1'b1;
				addr_p = AddrW'(id_q - IdW'(1));
			end
			OP_RPT_PRI: begin
				re_b = 1'b1;
				addr_b = slot_addr(pd_q);
			end
			default: begin
			end
		endcase
	end

	// slot and position memories
	always_ff @(posedge clk) begin
		if (we_h) begin
			heap_mem[wa_h] <= wd_h;
		end
		if (we_p) begin
			pos_mem[wa_p] <= wd_p;
		end
		if (re_a) begin
			ra_q <= heap_mem[addr_a];
		end
		if (re_b) begin
			rb_q <= heap_mem[addr_b];
		end
		if (re_p) begin
			pd_q <= pos_mem[addr_p];
			pv_q <= map_vld_q[addr_p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			min_first_q <= 1'b1;
			map_vld_q <= '0;
		end else begin
			case (op)
				OP_INS: fill_q <= fill_q + SlotW'(1);
				OP_REM: begin
					fill_q <= fill_q - SlotW'(1);
					map_vld_q[AddrW'(ra_q.id - IdW'(1))] <= 1'b0;
				end
				OP_INV: min_first_q <= ~min_first_q;
				OP_FIN: map_vld_q[AddrW'(cur_q.id - IdW'(1))] <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				act_q <= in_action;
				id_q <= in_id;
				val_q <= in_pri;
			end
			OP_INS: begin
				p_q <= fill_q + SlotW'(1);
				cur_q <= '{id: id_q, pri: val_q};
			end
			OP_CHG: begin
				p_q <= pd_q;
				cur_q <= '{id: id_q, pri: val_q};
			end
			OP_REM: begin
				p_q <= SlotW'(1);
				cur_q <= rb_q;
			end
			OP_INV: i_q <= SlotW'(1);
			OP_UP_MOVE: p_q <= {1'b0, p_q[SlotW-1:1]};
			OP_DN_MOVE: p_q <= cidx;
			OP_FIN: i_q <= i_q + SlotW'(1);
			OP_INV_LD: begin
				p_q <= i_q;
				cur_q <= ra_q;
			end
			OP_RPT_OUT: begin
				is_empty_q <= fill_q == '0;
				held_count_q <= fill_q;
				top_element_q <= (fill_q == '0) ? '0 : ra_q.id;
				top_priority_q <= (fill_q == '0) ? '0 : ra_q.pri;
				element_present_q <= present;
				element_priority_q <= present ? rb_q.pri : '0;
			end
			default: begin
			end
		endcase
	end

	assign is_empty = is_empty_q;
	assign held_count = held_count_q;
	assign top_element = top_element_q;
	assign top_priority = top_priority_q;
	assign element_present = element_present_q;
	assign element_priority = element_priority_q;

endmodule

// File: hw/rtl/ihpq_ctrl.sv
module ihpq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input ihpq_pkg::stat_t stat,
	output ihpq_pkg::op_t op
);
	import ihpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_CHG,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_FIN,
		S_INV_CHK,
		S_INV_LD,
		S_RPT,
		S_RPT_PRI,
		S_OUT
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		op = OP_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.act)
					ACT_PUT: begin
						if (!stat.id_ok) begin
							state_d = S_RPT;
						end else if (stat.pos_hit) begin
							op = OP_CHG_RD;
							state_d = S_CHG;
						end else if (stat.heap_full) begin
							state_d = S_RPT;
						end else begin
							op = OP_INS;
							state_d = S_UP_RD;
						end
					end
					ACT_POP: begin
						if (stat.heap_empty) begin
							state_d = S_RPT;
						end else begin
							op = OP_REM;
							state_d = stat.heap_one ? S_RPT : S_DN_RD;
						end
					end
					ACT_INV: begin
						op = OP_INV;
						state_d = S_INV_CHK;
					end
					default: state_d = S_RPT;
				endcase
			end
			S_CHG: begin
				op = OP_CHG;
				state_d = stat.chg_up ? S_UP_RD : (stat.chg_dn ? S_DN_RD : S_FIN);
			end
			S_UP_RD: begin
				if (stat.has_parent) begin
					op = OP_UP_RD;
					state_d = S_UP_CMP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_UP_CMP: begin
				if (stat.up_go) begin
					op = OP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_RD: begin
				if (stat.has_child) begin
					op = OP_DN_RD;
					state_d = S_DN_CMP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_go) begin
					op = OP_DN_MOVE;
					state_d = S_DN_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				op = OP_FIN;
				state_d = (stat.act == ACT_INV) ? S_INV_CHK : S_RPT;
			end
			S_INV_CHK: begin
				if (stat.inv_more) begin
					op = OP_INV_RD;
					state_d = S_INV_LD;
				end else begin
					state_d = S_RPT;
				end
			end
			S_INV_LD: begin
				op = OP_INV_LD;
				state_d = S_UP_RD;
			end
			S_RPT: begin
				op = OP_RPT_RD;
				state_d = S_RPT_PRI;
			end
			S_RPT_PRI: begin
				op = OP_RPT_PRI;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					op = OP_RPT_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_RPT_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/indexed_heap_priority_queue_unit.sv
// flow: query, bad ids and remove with 0 or 1 held go from dispatch straight to the report read states
// sift: each level moved takes a read and a compare-move step; it stops at root or leaf or when the compare stops it
// insert and remove add the final write plus the sift; change adds a position-slot read and a compare plus any sift
// invert adds the order flip plus, for every held slot, a read, a load, its sift-up and the final write
// one word in flight, next word taken once the result word is loaded; loading waits while the last result is stalled
// reset: async low clears count, position map valid bits and sets smallest-first order
module indexed_heap_priority_queue_unit (
	input logic clk,
	input logic arst_n,
	ihpq_in_if.sink in_ch,
	ihpq_out_if.source out_ch
);
	import ihpq_pkg::*;

	op_t op;
	stat_t stat;

	ihpq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.stat(stat),
		.op(op)
	);

	ihpq_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.in_action(in_ch.action),
		.in_id(in_ch.element_id),
		.in_pri(in_ch.priority_value),
		.stat(stat),
		.is_empty(out_ch.is_empty),
		.held_count(out_ch.held_count),
		.top_element(out_ch.top_element),
		.top_priority(out_ch.top_priority),
		.element_present(out_ch.element_present),
		.element_priority(out_ch.element_priority)
	);

endmodule

// File: hw/rtl/ihpq_checker.sv
module ihpq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_empty,
	input logic [6:0] held_count,
	input logic [6:0] top_element,
	input logic [31:0] top_priority,
	input logic element_present,
	input logic [31:0] element_priority
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(held_count) && $stable(top_element))
		else $error("result word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (held_count == 7'd0)))
		else $error("empty flag disagrees with count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_element == 7'd0 && top_priority == 32'd0
			&& !element_present)
		else $error("empty heap reports a top");

	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !element_present |-> element_priority == 32'd0)
		else $error("absent element has a priority");

endmodule

bind indexed_heap_priority_queue_unit ihpq_checker u_ihpq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.is_empty(out_ch.is_empty),
	.held_count(out_ch.held_count),
	.top_element(out_ch.top_element),
	.top_priority(out_ch.top_priority),
	.element_present(out_ch.element_present),
	.element_priority(out_ch.element_priority)
);
